FILE: sv/chol_pkg.sv
package chol_pkg;
  localparam int MaxOrder = 8;
  localparam int DataWidth = 32;
  localparam int AddrW = 6;
  localparam int IdxW = 3;
  localparam int AccW = 64;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [AccW-1:0] acc_t;
  typedef logic [IdxW-1:0] idx_t;
  typedef logic [AddrW-1:0] addr_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_RED_INIT,
    ST_RED_RD,
    ST_RED_MUL,
    ST_RED_ACC,
    ST_CHECK,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_WR,
    ST_OUT_RD,
    ST_OUT,
    ST_FAIL
  } state_t;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;
endpackage

FILE: sv/chol_if.sv
interface chol_in_if;
  import chol_pkg::*;
  logic  valid;
  logic  ready;
  data_t element_value;
  logic  is_last_element;
  modport source (output valid, element_value, is_last_element, input ready);
  modport sink (input valid, element_value, is_last_element, output ready);
endinterface

interface chol_out_if;
  import chol_pkg::*;
  logic  valid;
  logic  ready;
  data_t factor_value;
  logic  status;
  logic  is_last_result;
  modport source (output valid, factor_value, status, is_last_result, input ready);
  modport sink (input valid, factor_value, status, is_last_result, output ready);
endinterface

FILE: sv/cholesky_decomposition_top.sv
// Cholesky factor of an n x n (n = cfg matrix size, 1..8) Q8.24 matrix. Words load one per
// cycle in row-major order; the last flag starts factoring, during which in.ready is low.
// One shared multiplier, a bit-serial square root (one per column) and a bit-serial
// divider (one quotient per factor element) run under a sequencer over a 64-entry store.
// Each inner product term of a reduction is read, multiplied and then accumulated in turn.
// The n*n result words then leave as out.ready takes them, or one failure word if the
// matrix is not positive definite. in.ready stays low until the last word has been issued.
module cholesky_decomposition_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  chol_in_if.sink     in_ch,
  chol_out_if.source  out_ch
);
  import chol_pkg::*;

  logic [3:0] size_r;
  state_t     state_r, state_nxt;
  logic [6:0] pos_r;
  idx_t       j_r, i_r, k_r, r_r, c_r;
  acc_t       acc_r;
  acc_t       red_r [MaxOrder];
  data_t      mem [MaxOrder*MaxOrder];
  data_t      rd_r, a_r;
  logic       phase_r;
  acc_t       prod_r;
  logic [63:0] sq_x_r, sq_res_r, sq_bit_r;
  logic [31:0] s_r;
  logic [67:0] num_r;
  logic [67:0] rem_r;
  logic [6:0]  dcnt_r;
  logic        neg_r;
  logic        ov_valid_r, ov_status_r, ov_last_r;
  data_t       ov_data_r;

  logic [3:0] n;
  assign n = (size_r == 4'd0) ? 4'd1 : (size_r > 4'(MaxOrder)) ? 4'(MaxOrder) : size_r;
  logic [6:0] total;
  assign total = 7'(n) * 7'(n);
  idx_t nm1;
  assign nm1 = idx_t'(n - 4'd1);

  logic in_fire, out_fire;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign in_ch.ready = (state_r == ST_LOAD);

  // row = pos / n by reciprocal multiply, exact for pos < 64
  logic [10:0] recip;
  always_comb begin
    case (n)
      4'd1: recip = 11'd1024;
      4'd2: recip = 11'd512;
      4'd3: recip = 11'd342;
      4'd4: recip = 11'd256;
      4'd5: recip = 11'd205;
      4'd6: recip = 11'd171;
      4'd7: recip = 11'd147;
      default: recip = 11'd128;
    endcase
  end

  logic [17:0] lrow_prod;
  assign lrow_prod = 18'(pos_r) * 18'(recip);
  logic [6:0] lrow, lcol;
  assign lrow = 7'(lrow_prod >> 10);
  assign lcol = pos_r - lrow * 7'(n);

  function automatic addr_t ad(idx_t r, idx_t c);
    return {r, c};
  endfunction

  // divider helpers
  logic [67:0] rem_sh;
  logic [31:0] half;
  assign rem_sh = {rem_r[66:0], num_r[67]};
  assign half = s_r >> 1;
  logic [63:0] mag, q;
  assign mag = red_r[i_r][63] ? 64'(-red_r[i_r]) : 64'(red_r[i_r]);
  assign q = num_r[63:0];

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:     if (in_fire && in_ch.is_last_element) state_nxt = ST_RED_INIT;
      ST_RED_INIT: state_nxt = (k_r == j_r) ? ST_RED_ACC : ST_RED_RD;
      ST_RED_RD:   if (phase_r) state_nxt = ST_RED_MUL;
      ST_RED_MUL:  state_nxt = ST_RED_ACC;
      ST_RED_ACC:  if (k_r == j_r || k_r + 1'b1 == j_r)
                     state_nxt = (i_r == nm1) ? ST_CHECK : ST_RED_INIT;
                   else state_nxt = ST_RED_RD;
      ST_CHECK:    state_nxt = (red_r[j_r] <= 0) ? ST_FAIL : ST_SQRT;
      ST_SQRT:     if (sq_bit_r == 64'd0) state_nxt = ST_DIV_INIT;
      ST_DIV_INIT: state_nxt = ST_DIV;
      ST_DIV:      if (dcnt_r == 7'd0) state_nxt = ST_DIV_WR;
      ST_DIV_WR:   if (i_r == nm1) state_nxt = (j_r == nm1) ? ST_OUT_RD : ST_RED_INIT;
                   else state_nxt = ST_DIV_INIT;
      ST_OUT_RD:   if (!ov_valid_r || out_fire) state_nxt = ST_OUT;
      ST_OUT:      state_nxt = (r_r == nm1 && c_r == nm1) ? ST_LOAD : ST_OUT_RD;
      ST_FAIL:     if (!ov_valid_r || out_fire) state_nxt = ST_LOAD;
      default:     state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      size_r <= 4'd8;
      pos_r <= '0;
      ov_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) size_r <= cfg_wdata;
      if (out_fire) ov_valid_r <= 1'b0;
      if (in_fire) begin
        pos_r <= in_ch.is_last_element ? 7'd0 : (pos_r < total ? pos_r + 7'd1 : pos_r);
      end
      if (state_r == ST_OUT) ov_valid_r <= 1'b1;
      if (state_r == ST_FAIL && (!ov_valid_r || out_fire)) ov_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      ST_LOAD: begin
        if (in_fire && pos_r < total)
          mem[ad(idx_t'(lrow), idx_t'(lcol))] <= in_ch.element_value;
        j_r <= '0;
        i_r <= '0;
        k_r <= '0;
        phase_r <= 1'b0;
        r_r <= '0;
        c_r <= '0;
      end
      ST_RED_INIT: begin
        rd_r <= mem[ad(i_r, j_r)];
        k_r <= '0;
        phase_r <= 1'b0;
        if (i_r < j_r) i_r <= j_r;
      end
      ST_RED_RD: begin
        if (!phase_r) begin
          if (k_r == '0) acc_r <= acc_t'(rd_r) <<< 16;
          a_r <= mem[ad(i_r, k_r)];
        end else begin
          rd_r <= mem[ad(j_r, k_r)];
        end
        phase_r <= ~phase_r;
      end
      ST_RED_MUL: prod_r <= acc_t'(a_r) * acc_t'(rd_r);
      ST_RED_ACC: begin
        if (k_r == j_r) begin
          red_r[i_r] <= (j_r == '0) ? acc_t'(rd_r) <<< 16 : acc_r - (prod_r >>> 8);
          i_r <= i_r + 1'b1;
        end else begin
          acc_r <= acc_r - (prod_r >>> 8);
          if (k_r + 1'b1 == j_r) begin
            red_r[i_r] <= acc_r - (prod_r >>> 8);
            i_r <= i_r + 1'b1;
            k_r <= '0;
          end else k_r <= k_r + 1'b1;
        end
      end
      ST_CHECK: begin
        sq_x_r <= 64'(red_r[j_r]);
        sq_res_r <= '0;
        sq_bit_r <= 64'd1 << 62;
        i_r <= j_r;
      end
      ST_SQRT: begin
        if (sq_bit_r != 64'd0) begin
          if (sq_x_r >= sq_res_r + sq_bit_r) begin
            sq_x_r <= sq_x_r - (sq_res_r + sq_bit_r);
            sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
          end else sq_res_r <= sq_res_r >> 1;
          sq_bit_r <= sq_bit_r >> 2;
        end else s_r <= (sq_res_r == 64'd0) ? 32'd1 : sq_res_r[31:0];
      end
      ST_DIV_INIT: begin
        neg_r <= red_r[i_r][63];
        num_r <= {mag, 4'd0} + 68'(half);
        rem_r <= '0;
        dcnt_r <= 7'd67;
      end
      ST_DIV: begin
        if (rem_sh >= 68'(s_r)) rem_r <= rem_sh - 68'(s_r);
        else rem_r <= rem_sh;
        num_r <= {num_r[66:0], rem_sh >= 68'(s_r)};
        dcnt_r <= dcnt_r - 7'd1;
      end
      ST_DIV_WR: begin
        if (q > 64'h7FFF_FFFF)
          mem[ad(i_r, j_r)] <= (neg_r && q >= 64'h8000_0000) ? data_t'(32'h8000_0000)
                               : neg_r ? -data_t'(q[31:0]) : data_t'(32'h7FFF_FFFF);
        else mem[ad(i_r, j_r)] <= neg_r ? -data_t'(q[31:0]) : data_t'(q[31:0]);
        if (i_r == nm1) begin
          j_r <= j_r + 1'b1;
          i_r <= j_r + 1'b1;
        end else i_r <= i_r + 1'b1;
      end
      ST_OUT_RD: rd_r <= (r_r >= c_r) ? mem[ad(r_r, c_r)] : mem[ad(c_r, r_r)];
      ST_OUT: begin
        ov_data_r <= rd_r;
        ov_status_r <= STATUS_OK;
        ov_last_r <= (r_r == nm1 && c_r == nm1);
        if (c_r == nm1) begin
          c_r <= '0;
          r_r <= r_r + 1'b1;
        end else c_r <= c_r + 1'b1;
      end
      ST_FAIL: begin
        if (!ov_valid_r || out_fire) begin
          ov_data_r <= '0;
          ov_status_r <= STATUS_FAIL;
          ov_last_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid = ov_valid_r;
  assign out_ch.factor_value = ov_data_r;
  assign out_ch.status = ov_status_r;
  assign out_ch.is_last_result = ov_last_r;

`ifndef ASSERT_OFF
  a_fail_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status == STATUS_FAIL |-> out_ch.is_last_result)
    else $error("failure word without last flag");
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_LOAD |-> !in_ch.ready)
    else $error("input ready while factoring");
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.is_last_element |=> state_r == ST_RED_INIT)
    else $error("factoring did not start");
`endif
endmodule

FILE: dv/cholesky_decomposition_checker.sv
module cholesky_decomposition_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  chol_in_if         in_ch,
  chol_out_if        out_ch,
  output int         mismatches,
  output int         pending,
  output int         words_checked,
  output int         not_pd_seen
);
  import chol_pkg::*;

  typedef struct packed {
    data_t value;
    logic  status;
    logic  last;
  } factor_word_t;

  factor_word_t factor_q[$];
  longint       factor_store[MaxOrder*MaxOrder];
  int           load_pos;
  logic [3:0]   order_reg;

  initial begin
    mismatches = 0;
    pending = 0;
    words_checked = 0;
    not_pd_seen = 0;
    foreach (factor_store[i]) factor_store[i] = 0;
  end

  function automatic int order_now();
    if (order_reg == 0) return 1;
    if (order_reg > MaxOrder) return MaxOrder;
    return order_reg;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint scale_round(longint x, longint unsigned s);
    longint unsigned u;
    longint unsigned q;
    longint r;
    u = (x < 0) ? longint'(-x) : x;
    q = (u + s / 2) / s;
    r = (x < 0) ? -longint'(q) : longint'(q);
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r;
  endfunction

  function automatic bit factor_columns(int n);
    longint red[MaxOrder];
    longint acc;
    longint p;
    longint unsigned s;
    for (int j = 0; j < n; j++) begin
      for (int i = j; i < n; i++) begin
        acc = factor_store[i*MaxOrder+j] * 65536;
        for (int k = 0; k < j; k++) begin
          p = factor_store[i*MaxOrder+k] * factor_store[j*MaxOrder+k];
          acc = acc - (p >>> 8);
        end
        red[i] = acc;
      end
      if (red[j] <= 0) return 0;
      s = int_sqrt(red[j]);
      if (s == 0) s = 1;
      for (int i = j; i < n; i++)
        factor_store[i*MaxOrder+j] = scale_round(red[i] * 16, s);
    end
    return 1;
  endfunction

  task automatic take_element(data_t v, logic last);
    int n;
    int a;
    int b;
    n = order_now();
    if (load_pos < n * n) begin
      factor_store[(load_pos / n) * MaxOrder + load_pos % n] = v;
      load_pos++;
    end
    if (!last) return;
    load_pos = 0;
    if (!factor_columns(n)) begin
      factor_q.push_back('{value: '0, status: STATUS_FAIL, last: 1'b1});
      return;
    end
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        a = (r >= c) ? r : c;
        b = (r >= c) ? c : r;
        factor_q.push_back('{value: data_t'(factor_store[a*MaxOrder+b]), status: STATUS_OK,
                             last: (r == n - 1 && c == n - 1)});
      end
  endtask

  task automatic report(string field, longint got, longint want);
    $display("mismatch on %s: got %0d, want %0d (word %0d)", field, got, want, words_checked);
    mismatches++;
  endtask

  always @(posedge clk) begin
    factor_word_t w;
    if (!rst_n) begin
      factor_q.delete();
      load_pos = 0;
      order_reg = 4'd8;
    end else begin
      if (cfg_we) order_reg = cfg_wdata;
      if (in_ch.valid && in_ch.ready) take_element(in_ch.element_value, in_ch.is_last_element);
      if (out_ch.valid && out_ch.ready) begin
        if (factor_q.size() == 0) begin
          report("unexpected word", out_ch.factor_value, 0);
        end else begin
          w = factor_q.pop_front();
          if (out_ch.factor_value !== w.value) report("factor_value", out_ch.factor_value, w.value);
          if (out_ch.status !== w.status) report("status", out_ch.status, w.status);
          if (out_ch.is_last_result !== w.last) report("is_last_result", out_ch.is_last_result, w.last);
          if (w.status == STATUS_FAIL) not_pd_seen++;
        end
        words_checked++;
      end
      pending = factor_q.size();
    end
  end
endmodule

FILE: dv/cholesky_decomposition_top_test.sv
module cholesky_decomposition_top_test;
  import chol_pkg::*;

  typedef enum {SPD_MATRIX, BROKEN_MATRIX, NOISE_MATRIX} matrix_kind_t;

  logic       clk = 0;
  logic       rst_n;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  int         mismatches;
  int         pending;
  int         words_checked;
  int         not_pd_seen;
  int         sent = 0;
  bit         quiet = 0;
  bit         hold_out = 0;
  data_t      mat[MaxOrder][MaxOrder];

  chol_in_if  in_ch();
  chol_out_if out_ch();

  cholesky_decomposition_top dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  cholesky_decomposition_checker checker_i (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .mismatches(mismatches), .pending(pending),
    .words_checked(words_checked), .not_pd_seen(not_pd_seen)
  );

  always #2 clk = ~clk;

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    out_ch.ready <= 0;
    forever begin
      if (hold_out) begin
        out_ch.ready <= 0;
        repeat (2000) @(posedge clk);
        hold_out = 0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end else begin
        out_ch.ready <= 0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end
  end

  task automatic push_word(data_t v, logic last);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.element_value <= v;
    in_ch.is_last_element <= last;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  // drain results, then let the block return to loading
  task automatic settle();
    in_ch.valid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_order(logic [3:0] v);
    settle();
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function automatic int clamp_order(logic [3:0] v);
    if (v == 0) return 1;
    if (v > MaxOrder) return MaxOrder;
    return v;
  endfunction

  function automatic void build(int n, matrix_kind_t kind);
    int x;
    int j;
    for (int r = 0; r < n; r++)
      for (int c = 0; c <= r; c++) begin
        if (kind == NOISE_MATRIX) begin
          mat[r][c] = $urandom;
          mat[c][r] = $urandom;
        end else if (r == c) begin
          mat[r][c] = n * (1 << 26) + $urandom_range(1, 1 << 26);
        end else begin
          x = int'($urandom_range(0, 1 << 27)) - (1 << 26);
          mat[r][c] = x;
          mat[c][r] = x;
        end
      end
    if (kind == BROKEN_MATRIX) begin
      j = $urandom_range(0, n - 1);
      mat[j][j] = -int'($urandom_range(0, 1 << 28));
    end
  endfunction

  task automatic send_matrix(int n, int count);
    for (int i = 0; i < count; i++)
      push_word((i < n * n) ? mat[i / n][i % n] : data_t'($urandom), i == count - 1);
  endtask

  initial begin
    logic [3:0] ord;
    int n;
    int cnt;
    int pick;
    matrix_kind_t kind;
    rst_n <= 0;
    cfg_we <= 0;
    cfg_wdata <= 0;
    in_ch.valid <= 0;
    in_ch.element_value <= 0;
    in_ch.is_last_element <= 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // fill the whole store first
    build(MaxOrder, SPD_MATRIX);
    send_matrix(MaxOrder, MaxOrder * MaxOrder);
    set_order(4'd1);
    push_word(32'sh7fff_ffff, 1);
    push_word(32'sh8000_0000, 1);
    push_word(0, 1);
    set_order(4'd0);
    push_word(1, 1);
    set_order(4'd2);
    build(2, SPD_MATRIX);
    send_matrix(2, 6);
    send_matrix(2, 2);
    set_order(4'd3);
    build(3, BROKEN_MATRIX);
    send_matrix(3, 9);

    // hold the output while a second matrix queues up behind the first
    set_order(4'd4);
    hold_out = 1;
    build(4, SPD_MATRIX);
    send_matrix(4, 16);
    build(4, NOISE_MATRIX);
    send_matrix(4, 16);

    while (sent < 450) begin
      quiet = sent > 380;
      if ($urandom_range(0, 7) == 0) begin
        pick = $urandom_range(0, 3);
        ord = (pick == 0) ? 4'd0 : (pick == 1) ? 4'd9 : (pick == 2) ? 4'd15 : 4'd8;
      end else begin
        ord = 4'($urandom_range(1, 5));
      end
      set_order(ord);
      n = clamp_order(ord);
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 19);
        kind = (pick < 15) ? SPD_MATRIX : (pick < 17) ? BROKEN_MATRIX : NOISE_MATRIX;
        build(n, kind);
        cnt = n * n;
        pick = $urandom_range(0, 19);
        if (pick == 0) cnt = n * n + $urandom_range(1, 3);
        else if (pick == 1 && n > 1) cnt = $urandom_range(1, n * n - 1);
        send_matrix(n, cnt);
      end
    end

    in_ch.valid <= 0;
    do @(negedge clk); while (pending != 0);
    repeat (100) @(posedge clk);
    $display("sent %0d element words over orders 1..8, checked %0d result words", sent,
             words_checked);
    $display("including %0d not-positive-definite outcomes", not_pd_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
